@@ hw/rtl/apsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared widths, codes and the command/status bundles between the
// controller and the datapath of the all-pairs shortest path unit.
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int unsigned NODE_W        = 5;
  localparam int unsigned NODE_LIM      = 32;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned DIST_W        = 24;
  localparam int unsigned WEIGHT_W      = 16;
  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned MAX_NODES_DEF = 32;

  localparam logic [DIST_W-1:0] UNREACH        = '1;
  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = CNT_W'(NODE_LIM);
  localparam logic [CNT_W-1:0]  CHAIN_FULL     = CNT_W'(NODE_LIM);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_EDGE  = 2'd0,
    FUNC_SOLVE = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACK     = 3'd0,
    ST_PATH    = 3'd1,
    ST_SAME    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_UNREACH = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RD_AB,
    RD_LOHI,
    RD_IK,
    RD_KJ
  } rd_sel_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_EDGE_RD,
    S_EDGE_CMP,
    S_EDGE_WR2,
    S_INIT,
    S_INIT_TAIL,
    S_ROW,
    S_ROW_WAIT,
    S_RELAX,
    S_RELAX_TAIL,
    S_Q_RD,
    S_Q_CHK,
    S_WALK,
    S_WALK_WT,
    S_EMIT_FIRST,
    S_EMIT_CHAIN
  } state_e;

  typedef struct packed {
    logic    clr_step;
    logic    latch;
    rd_sel_e rd_sel;
    logic    edge_wr_ab;
    logic    edge_wr_ba;
    logic    cnt_clear;
    logic    adv_ij;
    logic    adv_j;
    logic    row_next;
    logic    ini_step;
    logic    dik_load;
    logic    rlx_step;
    logic    q_load;
    logic    walk_step;
    logic    walk_load;
    logic    emit;
    status_e emit_code;
    logic    emit_first;
    logic    emit_chain;
  } cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic [FUNC_W-1:0] func;
    logic              range_bad;
    logic              same_node;
    logic              n_zero;
    logic              i_last;
    logic              j_last;
    logic              k_last;
    logic              d_unreach;
    logic              walk_more;
    logic              cur_bad;
    logic              walk_ok;
    logic              chain_last;
  } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/apsp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_ctrl
// Sequencer for the shortest path unit: clearing pass, edge update,
// Floyd-Warshall sweep and predecessor walk. Holds the solved flag.
// ----------------------------------------------------------------------------
module apsp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           cfg_wr_i,
  input  wire apsp_pkg::stat_t stat_i,
  output apsp_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  apsp_pkg::state_e state_q, state_d;
  logic             solved_q, solved_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= apsp_pkg::S_CLEAR;
      solved_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      solved_q <= solved_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    solved_d     = solved_q;
    cmd_o        = '0;
    cmd_o.rd_sel = apsp_pkg::RD_AB;

    case (state_q)
      apsp_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = apsp_pkg::S_IDLE;
        end
      end
      apsp_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = apsp_pkg::S_DISPATCH;
        end
      end
      apsp_pkg::S_DISPATCH: begin
        case (stat_i.func)
          apsp_pkg::FUNC_EDGE: begin
            if (stat_i.range_bad) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_code = apsp_pkg::ST_RANGE;
              state_d         = apsp_pkg::S_IDLE;
            end else begin
              state_d = apsp_pkg::S_EDGE_RD;
            end
          end
          apsp_pkg::FUNC_SOLVE: begin
            if (stat_i.n_zero) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_code = apsp_pkg::ST_ACK;
              solved_d        = 1'b1;
              state_d         = apsp_pkg::S_IDLE;
            end else begin
              cmd_o.cnt_clear = 1'b1;
              state_d         = apsp_pkg::S_INIT;
            end
          end
          apsp_pkg::FUNC_QUERY: begin
            if (stat_i.range_bad) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_code = apsp_pkg::ST_RANGE;
              state_d         = apsp_pkg::S_IDLE;
            end else if (stat_i.same_node) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_code = apsp_pkg::ST_SAME;
              state_d         = apsp_pkg::S_IDLE;
            end else if (!solved_q) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_code = apsp_pkg::ST_UNREACH;
              state_d         = apsp_pkg::S_IDLE;
            end else begin
              state_d = apsp_pkg::S_Q_RD;
            end
          end
          default: begin
            state_d = apsp_pkg::S_IDLE;
          end
        endcase
      end
      apsp_pkg::S_EDGE_RD: begin
        state_d = apsp_pkg::S_EDGE_CMP;
      end
      apsp_pkg::S_EDGE_CMP: begin
        cmd_o.edge_wr_ab = 1'b1;
        state_d          = apsp_pkg::S_EDGE_WR2;
      end
      apsp_pkg::S_EDGE_WR2: begin
        cmd_o.edge_wr_ba = 1'b1;
        cmd_o.emit       = 1'b1;
        cmd_o.emit_code  = apsp_pkg::ST_ACK;
        solved_d         = 1'b0;
        state_d          = apsp_pkg::S_IDLE;
      end
      apsp_pkg::S_INIT: begin
        cmd_o.ini_step = 1'b1;
        cmd_o.adv_ij   = 1'b1;
        if (stat_i.i_last && stat_i.j_last) begin
          state_d = apsp_pkg::S_INIT_TAIL;
        end
      end
      apsp_pkg::S_INIT_TAIL: begin
        cmd_o.cnt_clear = 1'b1;
        state_d         = apsp_pkg::S_ROW;
      end
      apsp_pkg::S_ROW: begin
        cmd_o.rd_sel = apsp_pkg::RD_IK;
        state_d      = apsp_pkg::S_ROW_WAIT;
      end
      apsp_pkg::S_ROW_WAIT: begin
        cmd_o.dik_load = 1'b1;
        state_d        = apsp_pkg::S_RELAX;
      end
      apsp_pkg::S_RELAX: begin
        cmd_o.rd_sel   = apsp_pkg::RD_KJ;
        cmd_o.rlx_step = 1'b1;
        cmd_o.adv_j    = 1'b1;
        if (stat_i.j_last) begin
          state_d = apsp_pkg::S_RELAX_TAIL;
        end
      end
      apsp_pkg::S_RELAX_TAIL: begin
        // The last write of the row lands here, before the next row is read.
        if (stat_i.i_last && stat_i.k_last) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = apsp_pkg::ST_ACK;
          solved_d        = 1'b1;
          state_d         = apsp_pkg::S_IDLE;
        end else begin
          cmd_o.row_next = 1'b1;
          state_d        = apsp_pkg::S_ROW;
        end
      end
      apsp_pkg::S_Q_RD: begin
        cmd_o.rd_sel = apsp_pkg::RD_LOHI;
        state_d      = apsp_pkg::S_Q_CHK;
      end
      apsp_pkg::S_Q_CHK: begin
        cmd_o.rd_sel = apsp_pkg::RD_LOHI;
        if (stat_i.d_unreach) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = apsp_pkg::ST_UNREACH;
          state_d         = apsp_pkg::S_IDLE;
        end else begin
          cmd_o.q_load = 1'b1;
          state_d      = apsp_pkg::S_WALK;
        end
      end
      apsp_pkg::S_WALK: begin
        if (stat_i.cur_bad) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = apsp_pkg::ST_UNREACH;
          state_d         = apsp_pkg::S_IDLE;
        end else if (stat_i.walk_more) begin
          cmd_o.walk_step = 1'b1;
          state_d         = apsp_pkg::S_WALK_WT;
        end else if (stat_i.walk_ok) begin
          state_d = apsp_pkg::S_EMIT_FIRST;
        end else begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = apsp_pkg::ST_UNREACH;
          state_d         = apsp_pkg::S_IDLE;
        end
      end
      apsp_pkg::S_WALK_WT: begin
        cmd_o.walk_load = 1'b1;
        state_d         = apsp_pkg::S_WALK;
      end
      apsp_pkg::S_EMIT_FIRST: begin
        cmd_o.emit_first = 1'b1;
        state_d          = apsp_pkg::S_EMIT_CHAIN;
      end
      apsp_pkg::S_EMIT_CHAIN: begin
        cmd_o.emit_chain = 1'b1;
        if (stat_i.chain_last) begin
          state_d = apsp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = apsp_pkg::S_IDLE;
      end
    endcase

    // A node count write invalidates any earlier solution.
    if (cfg_wr_i) begin
      solved_d = 1'b0;
    end
  end

  assign busy_o = (state_q != apsp_pkg::S_IDLE);

endmodule
`default_nettype wire

@@ hw/rtl/apsp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsp_datapath
// Distance and predecessor memories, loop counters, relaxation adder,
// predecessor walk and the result register.
// ----------------------------------------------------------------------------
module apsp_datapath #(
  parameter int unsigned MAX_NODES = apsp_pkg::MAX_NODES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_wr_i,
  input  wire logic [apsp_pkg::CNT_W-1:0]         cfg_data_i,
  input  wire logic [apsp_pkg::FUNC_W-1:0]        func_i,
  input  wire logic [apsp_pkg::NODE_W-1:0]        node_a_i,
  input  wire logic [apsp_pkg::NODE_W-1:0]        node_b_i,
  input  wire logic [apsp_pkg::WEIGHT_W-1:0]      weight_i,
  input  wire apsp_pkg::cmd_t                     cmd_i,
  output apsp_pkg::stat_t                         stat_o,
  output logic                                    result_valid_o,
  output logic [apsp_pkg::STATUS_W-1:0]           status_o,
  output logic [apsp_pkg::NODE_W-1:0]             path_node_o,
  output logic [apsp_pkg::DIST_W-1:0]             distance_o,
  output logic                                    last_o
);

  localparam int unsigned NW    = $clog2(MAX_NODES);
  localparam int unsigned AW    = 2 * NW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned LIM   = (MAX_NODES < apsp_pkg::NODE_LIM) ?
                                  MAX_NODES : apsp_pkg::NODE_LIM;
  localparam int unsigned CW    = apsp_pkg::CNT_W;
  localparam int unsigned NDW   = apsp_pkg::NODE_W;
  localparam int unsigned DW    = apsp_pkg::DIST_W;

  function automatic logic [AW-1:0] cell_addr(input logic [NDW-1:0] r,
                                              input logic [NDW-1:0] c);
    return {NW'(r), NW'(c)};
  endfunction

  // Memories
  logic [DW-1:0]  dist_mem [DEPTH];
  logic [NDW-1:0] pred_mem [DEPTH];
  logic [NDW-1:0] chain_q  [apsp_pkg::NODE_LIM];

  // Configuration and active node count
  logic [CW-1:0] node_count_q;
  logic [CW-1:0] n_act, n_m1;

  // Latched item
  logic [apsp_pkg::FUNC_W-1:0]   func_q;
  logic [NDW-1:0]                a_q, b_q, lo, hi;
  logic [apsp_pkg::WEIGHT_W-1:0] w_q;

  // Counters
  logic [AW-1:0]  clr_addr_q;
  logic [NDW-1:0] i_q, j_q, k_q;

  // Memory ports
  logic [AW-1:0]  rd_a_addr, rd_b_addr, pred_ra, dist_wa, pred_wa;
  logic [DW-1:0]  rd_a_q, rd_b_q, dist_wd;
  logic [NDW-1:0] pred_rd_q, pred_wd;
  logic           dist_we, pred_we;

  // Pipeline stages
  logic           ini_v_q, rlx_v_q, edge_upd_q;
  logic [NDW-1:0] ini_i_q, ini_j_q, rlx_j_q;
  logic [DW-1:0]  dik_q;
  logic [DW:0]    rlx_sum;
  logic [DW-1:0]  rlx_sat;
  logic           rlx_upd, edge_upd;

  // Walk
  logic [DW-1:0]  d_q;
  logic [NDW-1:0] cur_q;
  logic [CW-1:0]  len_q, steps_q, p_q;

  // Result register
  logic                        out_v_q, out_v_d;
  logic [apsp_pkg::STATUS_W-1:0] out_st_q, out_st_d;
  logic [NDW-1:0]              out_node_q, out_node_d;
  logic [DW-1:0]               out_dist_q, out_dist_d;
  logic                        out_last_q, out_last_d;

  assign n_act = (node_count_q < CW'(LIM)) ? node_count_q : CW'(LIM);
  assign n_m1  = n_act - 1'b1;
  assign lo    = (a_q < b_q) ? a_q : b_q;
  assign hi    = (a_q < b_q) ? b_q : a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= apsp_pkg::NODE_COUNT_RST;
    end else if (cfg_wr_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      w_q    <= weight_i;
    end
  end

  // Loop counters and clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.cnt_clear) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (cmd_i.adv_ij) begin
        if (stat_o.j_last) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end else if (cmd_i.adv_j) begin
        j_q <= j_q + 1'b1;
      end else if (cmd_i.row_next) begin
        j_q <= '0;
        if (stat_o.i_last) begin
          i_q <= '0;
          k_q <= k_q + 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      apsp_pkg::RD_AB:   rd_a_addr = cell_addr(a_q, b_q);
      apsp_pkg::RD_LOHI: rd_a_addr = cell_addr(lo, hi);
      apsp_pkg::RD_IK:   rd_a_addr = cell_addr(i_q, k_q);
      apsp_pkg::RD_KJ:   rd_a_addr = cell_addr(k_q, j_q);
      default:           rd_a_addr = cell_addr(a_q, b_q);
    endcase
  end

  assign rd_b_addr = cell_addr(i_q, j_q);
  assign pred_ra   = cmd_i.walk_step ? cell_addr(lo, cur_q) : cell_addr(k_q, j_q);

  // Relaxation: saturating sum through k against the current entry.
  assign rlx_sum  = {1'b0, dik_q} + {1'b0, rd_a_q};
  assign rlx_sat  = rlx_sum[DW] ? apsp_pkg::UNREACH : rlx_sum[DW-1:0];
  assign rlx_upd  = rlx_v_q && (rd_b_q > rlx_sat);
  assign edge_upd = {{(DW - apsp_pkg::WEIGHT_W){1'b0}}, w_q} < rd_a_q;

  always_comb begin
    dist_we = 1'b0;
    dist_wa = clr_addr_q;
    dist_wd = apsp_pkg::UNREACH;
    pred_we = 1'b0;
    pred_wa = cell_addr(ini_i_q, ini_j_q);
    pred_wd = ini_i_q;
    if (cmd_i.clr_step) begin
      dist_we = 1'b1;
    end else if (cmd_i.edge_wr_ab) begin
      dist_we = edge_upd;
      dist_wa = cell_addr(a_q, b_q);
      dist_wd = DW'(w_q);
    end else if (cmd_i.edge_wr_ba) begin
      dist_we = edge_upd_q;
      dist_wa = cell_addr(b_q, a_q);
      dist_wd = DW'(w_q);
    end else if (ini_v_q) begin
      if (ini_i_q == ini_j_q) begin
        dist_we = 1'b1;
        dist_wa = cell_addr(ini_i_q, ini_i_q);
        dist_wd = '0;
      end else begin
        pred_we = (rd_b_q != apsp_pkg::UNREACH);
      end
    end else if (rlx_v_q) begin
      dist_we = rlx_upd;
      dist_wa = cell_addr(i_q, rlx_j_q);
      dist_wd = rlx_sat;
      pred_we = rlx_upd;
      pred_wa = cell_addr(i_q, rlx_j_q);
      pred_wd = pred_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    rd_a_q <= dist_mem[rd_a_addr];
    rd_b_q <= dist_mem[rd_b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pred_we) begin
      pred_mem[pred_wa] <= pred_wd;
    end
    pred_rd_q <= pred_mem[pred_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ini_v_q <= 1'b0;
      rlx_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      ini_v_q <= cmd_i.ini_step;
      rlx_v_q <= cmd_i.rlx_step;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ini_i_q <= i_q;
    ini_j_q <= j_q;
    rlx_j_q <= j_q;
    if (cmd_i.edge_wr_ab) begin
      edge_upd_q <= edge_upd;
    end
    if (cmd_i.dik_load) begin
      dik_q <= rd_a_q;
    end
    if (cmd_i.q_load) begin
      d_q     <= rd_a_q;
      cur_q   <= hi;
      len_q   <= '0;
      steps_q <= '0;
    end else if (cmd_i.walk_step) begin
      chain_q[len_q[NDW-1:0]] <= cur_q;
      len_q   <= len_q + 1'b1;
      steps_q <= steps_q + 1'b1;
    end else if (cmd_i.walk_load) begin
      cur_q <= pred_rd_q;
    end
    if (cmd_i.emit_first) begin
      p_q <= len_q - 1'b1;
    end else if (cmd_i.emit_chain) begin
      p_q <= p_q - 1'b1;
    end
    out_st_q   <= out_st_d;
    out_node_q <= out_node_d;
    out_dist_q <= out_dist_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    out_v_d    = 1'b0;
    out_st_d   = cmd_i.emit_code;
    out_node_d = '0;
    out_dist_d = (cmd_i.emit_code == apsp_pkg::ST_UNREACH) ? apsp_pkg::UNREACH : '0;
    out_last_d = 1'b1;
    if (cmd_i.emit) begin
      out_v_d = 1'b1;
    end else if (cmd_i.emit_first) begin
      out_v_d    = 1'b1;
      out_st_d   = apsp_pkg::ST_PATH;
      out_node_d = lo;
      out_dist_d = d_q;
      out_last_d = 1'b0;
    end else if (cmd_i.emit_chain) begin
      out_v_d    = 1'b1;
      out_st_d   = apsp_pkg::ST_PATH;
      out_node_d = chain_q[p_q[NDW-1:0]];
      out_dist_d = d_q;
      out_last_d = (p_q == '0);
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.clr_done   = (clr_addr_q == {AW{1'b1}});
    stat_o.func       = func_q;
    stat_o.range_bad  = ({1'b0, a_q} >= n_act) || ({1'b0, b_q} >= n_act);
    stat_o.same_node  = (a_q == b_q);
    stat_o.n_zero     = (n_act == '0);
    stat_o.i_last     = ({1'b0, i_q} == n_m1);
    stat_o.j_last     = ({1'b0, j_q} == n_m1);
    stat_o.k_last     = ({1'b0, k_q} == n_m1);
    stat_o.d_unreach  = (rd_a_q == apsp_pkg::UNREACH);
    stat_o.walk_more  = (steps_q < n_act) && (cur_q != lo);
    stat_o.cur_bad    = ({1'b0, cur_q} >= n_act);
    stat_o.walk_ok    = (cur_q == lo) && (len_q != apsp_pkg::CHAIN_FULL);
    stat_o.chain_last = (p_q == '0);
  end

  assign result_valid_o = out_v_q;
  assign status_o       = out_st_q;
  assign path_node_o    = out_node_q;
  assign distance_o     = out_dist_q;
  assign last_o         = out_last_q;

endmodule
`default_nettype wire

@@ hw/rtl/all_pairs_shortest_path_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_unit
// Floyd-Warshall engine for an undirected weighted graph with path readout.
// ----------------------------------------------------------------------------
// After reset the distance memory is swept to unreachable, one entry a cycle,
// with busy high. Add edge gives a single result. Compute runs an init pass
// over all n*n entries, then relaxes row by row through each k in the
// one-entry-per-cycle relax pipeline. Query walks the predecessors one path
// node at a time, then gives one result per cycle.
// One item at a time; results are registered, so they appear in the cycle
// after they are formed, and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_unit #(
  parameter int unsigned MAX_NODES = apsp_pkg::MAX_NODES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [apsp_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [apsp_pkg::NODE_W-1:0]   node_a_i,
  input  wire logic [apsp_pkg::NODE_W-1:0]   node_b_i,
  input  wire logic [apsp_pkg::WEIGHT_W-1:0] weight_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [apsp_pkg::CNT_W-1:0]    cfg_data_i,
  output logic                               result_valid_o,
  output logic [apsp_pkg::STATUS_W-1:0]      status_o,
  output logic [apsp_pkg::NODE_W-1:0]        path_node_o,
  output logic [apsp_pkg::DIST_W-1:0]        distance_o,
  output logic                               last_o
);

  apsp_pkg::cmd_t  cmd;
  apsp_pkg::stat_t stat;
  logic            cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  apsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cfg_wr_i (cfg_wr),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  apsp_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_i       (cfg_wr),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .weight_i       (weight_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .path_node_o    (path_node_o),
    .distance_o     (distance_o),
    .last_o         (last_o)
  );

  // Every non-path result is a single transfer carrying last.
  a_single_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != apsp_pkg::ST_PATH) |-> last_o)
    else $error("status result without last");

  a_unreach_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == apsp_pkg::ST_UNREACH) |->
      (distance_o == apsp_pkg::UNREACH))
    else $error("unreachable result with finite distance");

  // A path streams without gaps until its last node.
  a_path_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o && (status_o == apsp_pkg::ST_PATH))
    else $error("gap inside path burst");

  a_stable_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> $stable(distance_o))
    else $error("distance changed within one path");

endmodule
`default_nettype wire
